// ----- src/top_p_token_sampler_core_macros.svh -----
// Assertion macros used by the checker of the top-p token sampler.
`ifndef TOP_P_TOKEN_SAMPLER_CORE_MACROS_SVH
`define TOP_P_TOKEN_SAMPLER_CORE_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define TPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequence in the cycle after the antecedent.
`define TPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tps_pkg.sv -----
// Package with the constants, types and register codes of the top-p token sampler.
`timescale 1ns / 1ps

package tps_pkg;

  localparam int unsigned VOCAB_MAX_DEF = 4096;
  localparam int unsigned EXP_DEPTH_DEF = 1024;

  localparam int unsigned LOGIT_W = 16;
  localparam int unsigned DRAW_W  = 16;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned TOPP_W  = 17;
  localparam int unsigned TOKEN_W = 12;
  localparam int unsigned SCALE_W = 24;
  localparam int unsigned E_W     = 25;
  localparam int unsigned P_W     = 24;
  localparam int unsigned NUM_W   = E_W + P_W;

  localparam logic [63:0]      EXP_STEP_Q32 = 64'd4228380001;
  localparam logic [E_W-1:0]   PROB_FLOOR   = E_W'(16);
  localparam logic [P_W-1:0]   PROB_MAX     = {P_W{1'b1}};
  localparam logic [TEMP_W-1:0] TEMP_RESET  = TEMP_W'(256);
  localparam logic [TOPP_W-1:0] TOPP_RESET  = TOPP_W'(58982);

  typedef enum logic [0:0] {
    REG_TEMPERATURE = 1'b0,
    REG_TOP_P       = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SMAX,
    ST_SMAX_WAIT,
    ST_EXP_RD,
    ST_EXP_DIV,
    ST_EXP_DIVW,
    ST_EXP_ROM,
    ST_EXP_WR,
    ST_NORM_RD,
    ST_NORM_DIV,
    ST_NORM_WAIT,
    ST_SEL_SCAN,
    ST_SEL_NEXT,
    ST_PICK_MUL,
    ST_PICK_ORD,
    ST_PICK_PRB,
    ST_PICK_CHK,
    ST_EMIT
  } state_e;

endpackage

// ----- src/tps_div.sv -----
// Shared restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module tps_div #(
  parameter int unsigned NW = 49,
  parameter int unsigned DW = 38
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_q, rem_d;
  logic [NW-1:0]    quo_q, quo_d;
  logic [DW-1:0]    den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NW-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    fits    = rem_sh >= {1'b0, den_q};
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      cnt_d  = CNT_W'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_d  = {quo_q[NW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      busy_d = cnt_q != CNT_W'(1);
      done_d = cnt_q == CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- src/tps_exp_rom.sv -----
// Registered-read ROM of exp(-k/64) in Q1.24, built at elaboration.
`timescale 1ns / 1ps

module tps_exp_rom #(
  parameter int unsigned DEPTH = tps_pkg::EXP_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  output logic [tps_pkg::E_W-1:0]  data_o
);

  import tps_pkg::*;

  typedef logic [E_W-1:0] rom_t [DEPTH];

  function automatic rom_t build_rom();
    rom_t         r;
    logic [95:0]  e;
    e = 96'd1 << 32;
    for (int k = 0; k < DEPTH; k++) begin
      r[k] = E_W'(e >> 8);
      e    = (e * {32'd0, EXP_STEP_Q32} + (96'd1 << 31)) >> 32;
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk_i) begin
    data_o <= ROM[addr_i];
  end

endmodule

// ----- src/top_p_token_sampler_core.sv -----
// Top level of the top-p token sampler: load memory, sequencer and register port.
`timescale 1ns / 1ps
// Usage:
// Logits enter on the slave stream, one transaction per cycle while s_axis_tready
// is high: tdata holds the signed Q8.8 logit in bits 15:0 and the Q0.16 draw in
// bits 31:16, and tlast marks the final logit of the vector. The draw is used
// only with the tlast transaction. Logits beyond VOCAB_MAX are dropped.
// After tlast the input is held off while the sequencer walks the stored vector
// with one shared serial divider: it scales the maximum and the n logits (through
// the divider only with a nonzero temperature), normalizes the n exponentials,
// makes ns selection passes for a nucleus of ns entries, then draws the token.
// Temperature and top_p are written on the APB port at byte addresses 0 and 4;
// the user must write them only while the block is idle, as the block itself
// does not enforce this.
// The sampled token leaves on the master stream in tdata bits 11:0 through an
// output register; a stalled receiver holds the sequencer in its last step,
// and loading of the next vector starts once the token is registered.
// Reset clears the load count and the output valid, sets the maximum to the
// most negative logit and both registers to their reset values; the memories
// need no clearing.
module top_p_token_sampler_core #(
  parameter int unsigned VOCAB_MAX       = tps_pkg::VOCAB_MAX_DEF,
  parameter int unsigned EXP_TABLE_DEPTH = tps_pkg::EXP_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // logit [15:0], random_draw [31:16]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // token [11:0], zero [15:12]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import tps_pkg::*;

  localparam int unsigned IW = $clog2(VOCAB_MAX);
  localparam int unsigned CW = $clog2(VOCAB_MAX + 1);
  localparam int unsigned SW = E_W + CW;
  localparam int unsigned AW = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned KW = P_W + IW;

  function automatic logic [SCALE_W-1:0] scaled_mag(logic signed [LOGIT_W-1:0] x);
    logic signed [SCALE_W-1:0] s;
    s = {x, 8'd0};
    return x[LOGIT_W-1] ? SCALE_W'(-s) : SCALE_W'(s);
  endfunction

  function automatic logic signed [SCALE_W-1:0] signed_quo(logic neg,
                                                           logic [NUM_W-1:0] q);
    logic [SCALE_W-1:0] m;
    m = q[SCALE_W-1:0];
    return neg ? SCALE_W'(-m) : SCALE_W'(m);
  endfunction

  state_e state_q, state_d;

  logic [CW-1:0]               n_q, n_d;
  logic signed [LOGIT_W-1:0]   max_q, max_d;
  logic [DRAW_W-1:0]           draw_q, draw_d;
  logic [TEMP_W-1:0]           temp_q;
  logic [TOPP_W-1:0]           topp_q;
  logic signed [SCALE_W-1:0]   smax_q, smax_d;
  logic signed [SCALE_W-1:0]   sval_q, sval_d;
  logic                        neg_q, neg_d;
  logic [CW-1:0]               i_q, i_d;
  logic [SW-1:0]               sum_q, sum_d;
  logic                        inr_q, inr_d;
  logic [CW-1:0]               m_q, m_d;
  logic [CW-1:0]               ns_q, ns_d;
  logic [SW-1:0]               cum_q, cum_d;
  logic [KW-1:0]               best_q, best_d;
  logic                        bv_q, bv_d;
  logic [KW-1:0]               prev_q, prev_d;
  logic                        first_q, first_d;
  logic                        pv_q, pv_d;
  logic [IW-1:0]               pidx_q, pidx_d;
  logic [SW-1:0]               r_q, r_d;
  logic [SW-1:0]               run_q, run_d;
  logic [IW-1:0]               tok_q, tok_d;
  logic [IW-1:0]               res_q, res_d;
  logic                        ov_q, ov_d;
  logic [IW-1:0]               otok_q, otok_d;

  logic [LOGIT_W-1:0] logit_mem [VOCAB_MAX];
  logic [E_W-1:0]     prob_mem  [VOCAB_MAX];
  logic [IW-1:0]      order_mem [VOCAB_MAX];

  logic               lg_we, pr_we, or_we;
  logic [IW-1:0]      lg_waddr, lg_raddr, pr_waddr, pr_raddr, or_waddr, or_raddr;
  logic [LOGIT_W-1:0] lg_wdata, lg_rdata;
  logic [E_W-1:0]     pr_wdata, pr_rdata;
  logic [IW-1:0]      or_wdata, or_rdata;

  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_num, div_quo;
  logic [SW-1:0]      div_den;

  logic [AW-1:0]      rom_addr;
  logic [E_W-1:0]     rom_data;

  logic signed [LOGIT_W-1:0] in_logit;
  logic                      cfg_wr;
  logic                      cfg_idx;

  logic signed [SCALE_W:0]   diff;
  logic [SCALE_W-2:0]        kidx;
  logic [E_W-1:0]            e_val;
  logic [P_W-1:0]            p_val;
  logic [KW-1:0]             cand;
  logic [SW-1:0]             cum_n;
  logic [SW-1:0]             run_n;
  logic [DRAW_W+SW-1:0]      prod;

  assign in_logit = s_axis_tdata[LOGIT_W-1:0];

  tps_div #(
    .NW (NUM_W),
    .DW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  tps_exp_rom #(
    .DEPTH (EXP_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  always_ff @(posedge clk_i) begin
    if (lg_we) begin
      logit_mem[lg_waddr] <= lg_wdata;
    end
    lg_rdata <= logit_mem[lg_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pr_we) begin
      prob_mem[pr_waddr] <= pr_wdata;
    end
    pr_rdata <= prob_mem[pr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (or_we) begin
      order_mem[or_waddr] <= or_wdata;
    end
    or_rdata <= order_mem[or_raddr];
  end

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[2];
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx_e'(cfg_idx))
      REG_TEMPERATURE: prdata = 32'(temp_q);
      REG_TOP_P:       prdata = 32'(topp_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q <= TEMP_RESET;
      topp_q <= TOPP_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_e'(cfg_idx))
        REG_TEMPERATURE: temp_q <= pwdata[TEMP_W-1:0];
        REG_TOP_P:       topp_q <= pwdata[TOPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    max_d    = max_q;
    draw_d   = draw_q;
    smax_d   = smax_q;
    sval_d   = sval_q;
    neg_d    = neg_q;
    i_d      = i_q;
    sum_d    = sum_q;
    inr_d    = inr_q;
    m_d      = m_q;
    ns_d     = ns_q;
    cum_d    = cum_q;
    best_d   = best_q;
    bv_d     = bv_q;
    prev_d   = prev_q;
    first_d  = first_q;
    pv_d     = pv_q;
    pidx_d   = pidx_q;
    r_d      = r_q;
    run_d    = run_q;
    tok_d    = tok_q;
    res_d    = res_q;
    otok_d   = otok_q;
    ov_d     = ov_q && !m_axis_tready;

    lg_we    = 1'b0;
    lg_waddr = n_q[IW-1:0];
    lg_wdata = s_axis_tdata[LOGIT_W-1:0];
    lg_raddr = i_q[IW-1:0];
    pr_we    = 1'b0;
    pr_waddr = i_q[IW-1:0];
    pr_wdata = '0;
    pr_raddr = i_q[IW-1:0];
    or_we    = 1'b0;
    or_waddr = ns_q[IW-1:0];
    or_wdata = ~best_q[IW-1:0];
    or_raddr = i_q[IW-1:0];
    div_start = 1'b0;
    div_num   = NUM_W'(scaled_mag(max_q));
    div_den   = SW'(temp_q);

    diff     = {smax_q[SCALE_W-1], smax_q} - {sval_q[SCALE_W-1], sval_q};
    kidx     = diff[SCALE_W:2];
    rom_addr = kidx[AW-1:0];
    e_val    = inr_q ? rom_data : '0;
    p_val    = (div_quo > NUM_W'(PROB_MAX)) ? PROB_MAX : div_quo[P_W-1:0];
    cand     = {pr_rdata[P_W-1:0], ~pidx_q};
    cum_n    = cum_q + SW'(best_q[KW-1:IW]);
    run_n    = run_q + SW'(pr_rdata);
    prod     = draw_q * cum_q;

    s_axis_tready = state_q == ST_LOAD;

    case (state_q)
      ST_LOAD: begin
        if (s_axis_tvalid) begin
          if (n_q < CW'(VOCAB_MAX)) begin
            lg_we = 1'b1;
            n_d   = n_q + 1'b1;
            if (in_logit > max_q) begin
              max_d = in_logit;
            end
          end
          if (s_axis_tlast) begin
            draw_d  = s_axis_tdata[LOGIT_W+DRAW_W-1:LOGIT_W];
            state_d = ST_SMAX;
          end
        end
      end
      ST_SMAX: begin
        i_d   = '0;
        sum_d = '0;
        if (temp_q == '0) begin
          smax_d  = SCALE_W'(max_q);
          state_d = ST_EXP_RD;
        end else begin
          div_start = 1'b1;
          neg_d     = max_q[LOGIT_W-1];
          state_d   = ST_SMAX_WAIT;
        end
      end
      ST_SMAX_WAIT: begin
        if (div_done) begin
          smax_d  = signed_quo(neg_q, div_quo);
          state_d = ST_EXP_RD;
        end
      end
      ST_EXP_RD: begin
        state_d = ST_EXP_DIV;
      end
      ST_EXP_DIV: begin
        if (temp_q == '0) begin
          sval_d  = SCALE_W'($signed(lg_rdata));
          state_d = ST_EXP_ROM;
        end else begin
          div_start = 1'b1;
          div_num   = NUM_W'(scaled_mag($signed(lg_rdata)));
          neg_d     = lg_rdata[LOGIT_W-1];
          state_d   = ST_EXP_DIVW;
        end
      end
      ST_EXP_DIVW: begin
        if (div_done) begin
          sval_d  = signed_quo(neg_q, div_quo);
          state_d = ST_EXP_ROM;
        end
      end
      ST_EXP_ROM: begin
        inr_d   = kidx < (SCALE_W-1)'(EXP_TABLE_DEPTH);
        state_d = ST_EXP_WR;
      end
      ST_EXP_WR: begin
        pr_we    = 1'b1;
        pr_wdata = e_val;
        sum_d    = sum_q + SW'(e_val);
        if (i_q + 1'b1 == n_q) begin
          i_d     = '0;
          m_d     = '0;
          state_d = ST_NORM_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_EXP_RD;
        end
      end
      ST_NORM_RD: begin
        state_d = ST_NORM_DIV;
      end
      ST_NORM_DIV: begin
        div_start = 1'b1;
        div_num   = {pr_rdata, P_W'(0)};
        div_den   = sum_q;
        state_d   = ST_NORM_WAIT;
      end
      ST_NORM_WAIT: begin
        if (div_done) begin
          pr_we    = 1'b1;
          pr_wdata = E_W'(p_val);
          if (E_W'(p_val) > PROB_FLOOR) begin
            m_d = m_q + 1'b1;
          end
          if (i_q + 1'b1 == n_q) begin
            i_d     = '0;
            pv_d    = 1'b0;
            bv_d    = 1'b0;
            first_d = 1'b1;
            ns_d    = '0;
            cum_d   = '0;
            state_d = ST_SEL_SCAN;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_NORM_RD;
          end
        end
      end
      ST_SEL_SCAN: begin
        if (i_q < n_q) begin
          i_d    = i_q + 1'b1;
          pv_d   = 1'b1;
          pidx_d = i_q[IW-1:0];
        end else begin
          pv_d = 1'b0;
        end
        if (pv_q && pr_rdata > PROB_FLOOR && (first_q || cand < prev_q) &&
            (!bv_q || cand > best_q)) begin
          best_d = cand;
          bv_d   = 1'b1;
        end
        if (i_q == n_q && !pv_q) begin
          state_d = ST_SEL_NEXT;
        end
      end
      ST_SEL_NEXT: begin
        or_we   = 1'b1;
        cum_d   = cum_n;
        ns_d    = ns_q + 1'b1;
        prev_d  = best_q;
        first_d = 1'b0;
        i_d     = '0;
        bv_d    = 1'b0;
        pv_d    = 1'b0;
        if (cum_n >= SW'({topp_q, 8'd0}) || ns_q + 1'b1 == m_q) begin
          state_d = ST_PICK_MUL;
        end else begin
          state_d = ST_SEL_SCAN;
        end
      end
      ST_PICK_MUL: begin
        r_d     = prod[DRAW_W+SW-1:DRAW_W];
        run_d   = '0;
        i_d     = '0;
        state_d = ST_PICK_ORD;
      end
      ST_PICK_ORD: begin
        state_d = ST_PICK_PRB;
      end
      ST_PICK_PRB: begin
        tok_d    = or_rdata;
        pr_raddr = or_rdata;
        state_d  = ST_PICK_CHK;
      end
      ST_PICK_CHK: begin
        run_d = run_n;
        if (r_q < run_n || i_q + 1'b1 == ns_q) begin
          res_d   = tok_q;
          state_d = ST_EMIT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_PICK_ORD;
        end
      end
      ST_EMIT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          otok_d  = res_q;
          n_d     = '0;
          max_d   = {1'b1, (LOGIT_W-1)'(0)};
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      n_q     <= '0;
      max_q   <= {1'b1, (LOGIT_W-1)'(0)};
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      max_q   <= max_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    draw_q  <= draw_d;
    smax_q  <= smax_d;
    sval_q  <= sval_d;
    neg_q   <= neg_d;
    i_q     <= i_d;
    sum_q   <= sum_d;
    inr_q   <= inr_d;
    m_q     <= m_d;
    ns_q    <= ns_d;
    cum_q   <= cum_d;
    best_q  <= best_d;
    bv_q    <= bv_d;
    prev_q  <= prev_d;
    first_q <= first_d;
    pv_q    <= pv_d;
    pidx_q  <= pidx_d;
    r_q     <= r_d;
    run_q   <= run_d;
    tok_q   <= tok_d;
    res_q   <= res_d;
    otok_q  <= otok_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = 16'(TOKEN_W'(otok_q));

endmodule

// ----- src/tps_checker.sv -----
// Port-level checker of the top-p token sampler, bound to the top level.
`timescale 1ns / 1ps
`include "top_p_token_sampler_core_macros.svh"

module tps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  `TPS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "Stalled token transaction changed or vanished.")
  `TPS_ASSERT_NEXT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "Input accepted while sampling.")
  `TPS_ASSERT_IMP(a_rise_from_busy, $rose(m_axis_tvalid), !$past(s_axis_tready), "Token appeared without a sampling run.")
  `TPS_ASSERT_IMP(a_token_pad, m_axis_tvalid, m_axis_tdata[15:12] == 4'd0, "Token padding bits are not zero.")

endmodule

bind top_p_token_sampler_core tps_checker u_tps_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
